/* design/wtsp_pkg.sv */
// wtsp_pkg: shared types, codes and helper functions for the type section parser
// depends on nothing; used by wtsp_decoder and wasm_type_section_parser
package wtsp_pkg;

   // default parameter values
   localparam int COUNT_WIDTH_DEF   = 32;
   localparam int LEB_MAX_BYTES_DEF = 10;

   // port widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 104;
   localparam int RSP_USER_W = 4;

   // event codes
   localparam logic [3:0] EV_PARTIAL = 4'd0;
   localparam logic [3:0] EV_LENGTH  = 4'd1;
   localparam logic [3:0] EV_FCOUNT  = 4'd2;
   localparam logic [3:0] EV_FOPEN   = 4'd3;
   localparam logic [3:0] EV_PCOUNT  = 4'd4;
   localparam logic [3:0] EV_PTYPE   = 4'd5;
   localparam logic [3:0] EV_RCOUNT  = 4'd6;
   localparam logic [3:0] EV_RTYPE   = 4'd7;
   localparam logic [3:0] EV_ERROR   = 4'd8;

   // error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_MARKER   = 2'd1;
   localparam logic [1:0] ERR_TYPE     = 2'd2;
   localparam logic [1:0] ERR_LEB_LONG = 2'd3;

   // function signature marker byte
   localparam logic [7:0] FUNC_MARKER = 8'h60;

   // value type bytes
   localparam logic [7:0] VT_BYTE_I32 = 8'h7F;
   localparam logic [7:0] VT_BYTE_I64 = 8'h7E;
   localparam logic [7:0] VT_BYTE_F32 = 8'h7D;
   localparam logic [7:0] VT_BYTE_F64 = 8'h7C;

   // one decoded result item
   typedef struct packed {
      logic [3:0]  event_res;
      logic [1:0]  value_type;
      logic [31:0] function_index;
      logic [31:0] slot_index;
      logic [31:0] decoded_count;
      logic        function_end;
      logic        section_end;
      logic [1:0]  error_code;
   } rsp_item_type;

   // place seven payload bits of a leb byte at their position in a 32-bit word
   function automatic logic [31:0] leb_place(input logic [6:0] bits, input logic [3:0] pos);
      logic [31:0] w;
      begin
         w = 32'(bits);
         case (pos)
            4'd0: leb_place = w;
            4'd1: leb_place = w << 7;
            4'd2: leb_place = w << 14;
            4'd3: leb_place = w << 21;
            4'd4: leb_place = w << 28;
            default: leb_place = 32'd0;
         endcase
      end
   endfunction

   // value type lookup: bit 2 is valid, bits 1:0 the type code
   function automatic logic [2:0] value_type_of(input logic [7:0] b);
      begin
         case (b)
            VT_BYTE_I32: value_type_of = 3'b100;
            VT_BYTE_I64: value_type_of = 3'b101;
            VT_BYTE_F32: value_type_of = 3'b110;
            VT_BYTE_F64: value_type_of = 3'b111;
            default: value_type_of = 3'b000;
         endcase
      end
   endfunction

endpackage

/* design/wtsp_pipe_reg.sv */
// wtsp_pipe_reg: one register stage with valid/ready flow control
// no dependencies; used for the request and response registers
module wtsp_pipe_reg #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic             valid_ff;
   logic             valid_in;
   logic [WIDTH-1:0] data_ff;

   // stage can load when empty or when its content leaves this cycle
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* design/wtsp_decoder.sv */
// wtsp_decoder: parse state and per-byte decode of the type section
// depends on wtsp_pkg; instantiated by wasm_type_section_parser
module wtsp_decoder #(
   parameter int COUNT_WIDTH   = wtsp_pkg::COUNT_WIDTH_DEF,
   parameter int LEB_MAX_BYTES = wtsp_pkg::LEB_MAX_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            section_byte,
   input  logic                  section_start,
   output wtsp_pkg::rsp_item_type result
);
   import wtsp_pkg::*;

   localparam int CNT_W = $clog2(LEB_MAX_BYTES);
   localparam logic [CNT_W-1:0] LEB_LAST = CNT_W'(LEB_MAX_BYTES - 1);

   // parse phases
   localparam logic [3:0] PH_SEC_LEN      = 4'd0;
   localparam logic [3:0] PH_FUNC_COUNT   = 4'd1;
   localparam logic [3:0] PH_MARKER       = 4'd2;
   localparam logic [3:0] PH_PARAM_COUNT  = 4'd3;
   localparam logic [3:0] PH_PARAM_TYPE   = 4'd4;
   localparam logic [3:0] PH_RESULT_COUNT = 4'd5;
   localparam logic [3:0] PH_RESULT_TYPE  = 4'd6;
   localparam logic [3:0] PH_DONE         = 4'd7;
   localparam logic [3:0] PH_ERROR        = 4'd8;

   logic [3:0]             phase_ff, phase_in, phase_cur;
   logic [COUNT_WIDTH-1:0] acc_ff, acc_in, acc_cur;
   logic [CNT_W-1:0]       leb_cnt_ff, leb_cnt_in, leb_cnt_cur;
   logic [COUNT_WIDTH-1:0] funcs_left_ff, funcs_left_in, funcs_left_cur;
   logic [COUNT_WIDTH-1:0] entries_left_ff, entries_left_in, entries_left_cur;
   logic [COUNT_WIDTH-1:0] cur_func_ff, cur_func_in, cur_func_cur;
   logic [COUNT_WIDTH-1:0] cur_slot_ff, cur_slot_in, cur_slot_cur;
   logic [1:0]             err_ff, err_in, err_cur;

   logic [31:0]            leb_bits;
   logic [COUNT_WIDTH-1:0] leb_value;
   logic [2:0]             vt_lookup;
   logic [COUNT_WIDTH-1:0] funcs_dec;
   logic [COUNT_WIDTH-1:0] entries_dec;
   logic                   is_count_phase;
   rsp_item_type           res;

   // a section start decodes this byte from the reset state
   always_comb begin
      if (section_start) begin
         phase_cur        = PH_SEC_LEN;
         acc_cur          = '0;
         leb_cnt_cur      = '0;
         funcs_left_cur   = '0;
         entries_left_cur = '0;
         cur_func_cur     = '0;
         cur_slot_cur     = '0;
         err_cur          = ERR_NONE;
      end else begin
         phase_cur        = phase_ff;
         acc_cur          = acc_ff;
         leb_cnt_cur      = leb_cnt_ff;
         funcs_left_cur   = funcs_left_ff;
         entries_left_cur = entries_left_ff;
         cur_func_cur     = cur_func_ff;
         cur_slot_cur     = cur_slot_ff;
         err_cur          = err_ff;
      end
   end

   // leb accumulation, value type lookup and counter decrements
   assign leb_bits    = leb_place(section_byte[6:0], 4'(leb_cnt_cur));
   assign leb_value   = acc_cur | leb_bits[COUNT_WIDTH-1:0];
   assign vt_lookup   = value_type_of(section_byte);
   assign funcs_dec   = funcs_left_cur - COUNT_WIDTH'(1);
   assign entries_dec = entries_left_cur - COUNT_WIDTH'(1);
   assign is_count_phase = (phase_cur == PH_SEC_LEN) || (phase_cur == PH_FUNC_COUNT) ||
                           (phase_cur == PH_PARAM_COUNT) || (phase_cur == PH_RESULT_COUNT);

   // next state and result for this byte
   always_comb begin
      phase_in        = phase_cur;
      acc_in          = acc_cur;
      leb_cnt_in      = leb_cnt_cur;
      funcs_left_in   = funcs_left_cur;
      entries_left_in = entries_left_cur;
      cur_func_in     = cur_func_cur;
      cur_slot_in     = cur_slot_cur;
      err_in          = err_cur;
      res             = '0;

      if (is_count_phase) begin
         if (section_byte[7]) begin
            // continuation byte
            if (leb_cnt_cur == LEB_LAST) begin
               err_in   = ERR_LEB_LONG;
               phase_in = PH_ERROR;
            end else begin
               acc_in     = leb_value;
               leb_cnt_in = leb_cnt_cur + CNT_W'(1);
            end
         end else begin
            // number complete
            acc_in            = '0;
            leb_cnt_in        = '0;
            res.decoded_count = 32'(leb_value);
            case (phase_cur)
               PH_SEC_LEN: begin
                  res.event_res = EV_LENGTH;
                  phase_in      = PH_FUNC_COUNT;
               end
               PH_FUNC_COUNT: begin
                  res.event_res = EV_FCOUNT;
                  funcs_left_in = leb_value;
                  cur_func_in   = '0;
                  if (leb_value == '0) begin
                     res.section_end = 1'b1;
                     phase_in        = PH_DONE;
                  end else begin
                     phase_in = PH_MARKER;
                  end
               end
               PH_PARAM_COUNT: begin
                  res.event_res   = EV_PCOUNT;
                  entries_left_in = leb_value;
                  cur_slot_in     = '0;
                  phase_in        = (leb_value == '0) ? PH_RESULT_COUNT : PH_PARAM_TYPE;
               end
               default: begin
                  res.event_res   = EV_RCOUNT;
                  entries_left_in = leb_value;
                  cur_slot_in     = '0;
                  if (leb_value == '0) begin
                     // empty result list closes the function
                     res.function_end = 1'b1;
                     funcs_left_in    = funcs_dec;
                     if (funcs_dec == '0) begin
                        res.section_end = 1'b1;
                        phase_in        = PH_DONE;
                     end else begin
                        cur_func_in = cur_func_cur + COUNT_WIDTH'(1);
                        phase_in    = PH_MARKER;
                     end
                  end else begin
                     phase_in = PH_RESULT_TYPE;
                  end
               end
            endcase
         end
      end else begin
         case (phase_cur)
            PH_MARKER: begin
               if (section_byte != FUNC_MARKER) begin
                  err_in   = ERR_MARKER;
                  phase_in = PH_ERROR;
               end else begin
                  res.event_res = EV_FOPEN;
                  phase_in      = PH_PARAM_COUNT;
               end
            end
            PH_PARAM_TYPE, PH_RESULT_TYPE: begin
               if (!vt_lookup[2]) begin
                  err_in   = ERR_TYPE;
                  phase_in = PH_ERROR;
               end else begin
                  res.event_res   = (phase_cur == PH_PARAM_TYPE) ? EV_PTYPE : EV_RTYPE;
                  res.value_type  = vt_lookup[1:0];
                  res.slot_index  = 32'(cur_slot_cur);
                  cur_slot_in     = cur_slot_cur + COUNT_WIDTH'(1);
                  entries_left_in = entries_dec;
                  if (entries_dec == '0) begin
                     if (phase_cur == PH_PARAM_TYPE) begin
                        phase_in = PH_RESULT_COUNT;
                     end else begin
                        // last result type closes the function
                        res.function_end = 1'b1;
                        funcs_left_in    = funcs_dec;
                        if (funcs_dec == '0) begin
                           res.section_end = 1'b1;
                           phase_in        = PH_DONE;
                        end else begin
                           cur_func_in = cur_func_cur + COUNT_WIDTH'(1);
                           phase_in    = PH_MARKER;
                        end
                     end
                  end
               end
            end
            PH_DONE: begin
               // trailing bytes are ignored
            end
            default: begin
               phase_in = PH_ERROR;
            end
         endcase
      end

      // sticky error overrides everything
      if (phase_in == PH_ERROR) begin
         res            = '0;
         res.event_res  = EV_ERROR;
         res.error_code = err_in;
      end
      res.function_index = 32'(cur_func_in);
   end

   assign result = res;

   // parse state, advanced once per byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_SEC_LEN;
         acc_ff          <= '0;
         leb_cnt_ff      <= '0;
         funcs_left_ff   <= '0;
         entries_left_ff <= '0;
         cur_func_ff     <= '0;
         cur_slot_ff     <= '0;
         err_ff          <= ERR_NONE;
      end else if (step) begin
         phase_ff        <= phase_in;
         acc_ff          <= acc_in;
         leb_cnt_ff      <= leb_cnt_in;
         funcs_left_ff   <= funcs_left_in;
         entries_left_ff <= entries_left_in;
         cur_func_ff     <= cur_func_in;
         cur_slot_ff     <= cur_slot_in;
         err_ff          <= err_in;
      end
   end

endmodule

/* design/wasm_type_section_parser.sv */
// wasm_type_section_parser: top level of the streaming type section parser
// depends on wtsp_pkg, wtsp_pipe_reg and wtsp_decoder
//
// Usage:
//   The req_ channel carries one byte of a type section per request, with
//   req_tuser set on the first byte of a section to restart parsing. The
//   rsp_ channel returns exactly one result per request, in order: the event
//   kind on rsp_tuser, the decoded fields on rsp_tdata, and rsp_tlast on the
//   byte that completes the section.
//   Path: a request accepted sits in the request register; its result is
//   decoded combinationally from there and registered in the response
//   register, which shows it on rsp_ until it is taken.
//   Throughput: one request per cycle while rsp_tready is high, bounded
//   only by the single pass of leb shift-or, compares and counter updates
//   between the two registers.
//   Reset: clears both registers and puts the parser in the state that reads
//   the section length; the first byte after reset starts a section even
//   without req_tuser.
//   Stall: when rsp_tready is low the result register holds, the request
//   register fills, and req_tready drops until the result is taken; no
//   result is lost or repeated.
module wasm_type_section_parser #(
   parameter int COUNT_WIDTH   = wtsp_pkg::COUNT_WIDTH_DEF,
   parameter int LEB_MAX_BYTES = wtsp_pkg::LEB_MAX_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [wtsp_pkg::REQ_DATA_W-1:0] req_tdata,  // [7:0] section_byte
   input  logic [0:0]                      req_tuser,  // [0] section_start
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [1:0] value_type, [33:2] function_index, [65:34] slot_index,
   // [97:66] decoded_count, [98] function_end, [100:99] error_code, [103:101] zero
   output logic [wtsp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [wtsp_pkg::RSP_USER_W-1:0] rsp_tuser,  // [3:0] event_res
   output logic                            rsp_tlast   // section_end
);
   import wtsp_pkg::*;

   localparam int REQ_W = REQ_DATA_W + 1;
   localparam int RSP_W = RSP_DATA_W + RSP_USER_W + 1;

   logic             in_valid;
   logic [REQ_W-1:0] in_data;
   logic             out_ready;
   logic             step;
   rsp_item_type     result;
   logic [RSP_W-1:0] rsp_pack;
   logic [RSP_W-1:0] rsp_reg;

   // request register
   wtsp_pipe_reg #(
      .WIDTH(REQ_W)
   ) u_req_reg (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_data  ({req_tuser, req_tdata}),
      .out_valid(in_valid),
      .out_ready(out_ready),
      .out_data (in_data)
   );

   // the parser advances when a byte moves into the response register
   assign step = in_valid && out_ready;

   wtsp_decoder #(
      .COUNT_WIDTH  (COUNT_WIDTH),
      .LEB_MAX_BYTES(LEB_MAX_BYTES)
   ) u_decoder (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .section_byte (in_data[REQ_DATA_W-1:0]),
      .section_start(in_data[REQ_DATA_W]),
      .result       (result)
   );

   // pack result: tlast on top, tuser next, tdata below
   assign rsp_pack = {result.section_end,
                      result.event_res,
                      3'b000,
                      result.error_code,
                      result.function_end,
                      result.decoded_count,
                      result.slot_index,
                      result.function_index,
                      result.value_type};

   // response register
   wtsp_pipe_reg #(
      .WIDTH(RSP_W)
   ) u_rsp_reg (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid),
      .in_ready (out_ready),
      .in_data  (rsp_pack),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_data (rsp_reg)
   );

   assign rsp_tdata = rsp_reg[RSP_DATA_W-1:0];
   assign rsp_tuser = rsp_reg[RSP_DATA_W +: RSP_USER_W];
   assign rsp_tlast = rsp_reg[RSP_W-1];

endmodule
